### rtl/core/vmi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vmi_pkg
// shared types and constants of the vertex morph interpolator
// ----------------------------------------------------------------------------
package vmi_pkg;

  localparam int VERTEX_COUNT = 1024;
  localparam int FRAC_BITS    = 16;
  localparam int IDX_W        = 10;
  localparam int COMP_W       = 32;
  localparam int T_W          = 17;
  localparam int T_FRAC       = 16;
  localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;
  localparam int QW           = FRAC_BITS + 3;
  localparam int REM_W        = COMP_W + FRAC_BITS + 3;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    ACT_LOAD_START = 2'd0,
    ACT_LOAD_END   = 2'd1,
    ACT_QUERY      = 2'd2,
    ACT_NONE       = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_POS  = 3'd0,
    KIND_NRM  = 3'd1,
    KIND_TANU = 3'd2,
    KIND_TANV = 3'd3,
    KIND_TEX  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    OP_LOAD_START,
    OP_LOAD_END,
    OP_QUERY
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic [IDX_W-1:0]         idx;
    logic [2:0]               kind;
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
    logic [T_W-1:0]           t;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_MIX,
    ST_SHIFT,
    ST_SQ,
    ST_SQRT,
    ST_DINIT,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic pop;
    logic wr_start;
    logic wr_end;
    logic out_load;
  } ctl_t;

endpackage
`default_nettype wire

### rtl/core/vmi_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vmi_front
// accepts transactions, drops the ones that do nothing, clamps blend time
// ----------------------------------------------------------------------------
module vmi_front (
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         in_action,
  input  wire logic [vmi_pkg::IDX_W-1:0]          in_vertex_index,
  input  wire logic [2:0]                         in_vector_kind,
  input  wire logic signed [vmi_pkg::COMP_W-1:0]  in_comp_x,
  input  wire logic signed [vmi_pkg::COMP_W-1:0]  in_comp_y,
  input  wire logic signed [vmi_pkg::COMP_W-1:0]  in_comp_z,
  input  wire logic [vmi_pkg::T_W-1:0]            in_blend_time,
  input  wire logic                               q_full,
  output logic                                    q_push,
  output vmi_pkg::cmd_t                           q_cmd
);
  import vmi_pkg::*;

  logic keep;
  logic idx_ok;

  assign in_ready = !q_full;
  assign idx_ok   = 32'(in_vertex_index) < VERTEX_COUNT;

  always_comb begin
    keep       = 1'b0;
    q_cmd.op   = OP_QUERY;
    q_cmd.idx  = in_vertex_index;
    q_cmd.kind = in_vector_kind;
    q_cmd.x    = in_comp_x;
    q_cmd.y    = in_comp_y;
    q_cmd.z    = in_comp_z;
    q_cmd.t    = (in_blend_time > T_ONE) ? T_ONE : in_blend_time;
    case (action_t'(in_action))
      ACT_LOAD_START: begin
        q_cmd.op = OP_LOAD_START;
        keep     = in_vector_kind inside {[KIND_POS:KIND_TEX]};
      end
      ACT_LOAD_END: begin
        q_cmd.op = OP_LOAD_END;
        keep     = in_vector_kind inside {[KIND_POS:KIND_TANV]};
      end
      ACT_QUERY: begin
        q_cmd.op = OP_QUERY;
        keep     = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign q_push = in_valid && in_ready && keep && idx_ok;

endmodule
`default_nettype wire

### rtl/core/vmi_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vmi_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
module vmi_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire vmi_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output vmi_pkg::cmd_t      head
);
  import vmi_pkg::*;

  cmd_t               slot_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0]   cnt_r;

  assign full      = cnt_r == (FIFO_AW+1)'(FIFO_DEPTH);
  assign not_empty = cnt_r != '0;
  assign head      = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("push into full queue");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count slip");
`endif

endmodule
`default_nettype wire

### rtl/core/vmi_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vmi_back
// vertex tables, blend, iterative normalise and result register
// ----------------------------------------------------------------------------
module vmi_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              q_not_empty,
  input  wire vmi_pkg::cmd_t                     q_head,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [2:0]                             out_kind,
  output logic signed [vmi_pkg::COMP_W-1:0]      out_x,
  output logic signed [vmi_pkg::COMP_W-1:0]      out_y,
  output logic signed [vmi_pkg::COMP_W-1:0]      out_z,
  output logic                                   out_last_of_vertex
);
  import vmi_pkg::*;

  localparam int SA_W = IDX_W + 3;
  localparam int EA_W = IDX_W + 2;
  localparam int VW   = 3 * COMP_W;

  logic [VW-1:0] start_mem [2**SA_W];
  logic [VW-1:0] end_mem   [2**EA_W];
  logic [VW-1:0] start_rd_r, end_rd_r;

  state_t state_r, state_nxt;
  ctl_t   ctl;

  logic [IDX_W-1:0]          idx_r;
  logic [T_W-1:0]            t_r;
  logic [2:0]                k_r;
  logic [1:0]                c_r;
  logic signed [COMP_W-1:0]  vec_r [3];
  logic [COMP_W-1:0]         mag_r [3];
  logic [2:0]                neg_r;
  logic [63:0]               len_r;
  logic [COMP_W-1:0]         root_r;
  logic [4:0]                bit_r;
  logic [REM_W-1:0]          rem_r, den_r;
  logic [QW-1:0]             quo_r;
  logic [4:0]                it_r;

  logic                      out_valid_r, out_last_r;
  logic [2:0]                out_kind_r;
  logic signed [COMP_W-1:0]  out_x_r, out_y_r, out_z_r;

  logic signed [COMP_W-1:0]  mix_a, mix_b, mix_v;
  logic signed [COMP_W:0]    mix_d;
  logic signed [COMP_W+T_W+1:0] mix_p;
  logic signed [COMP_W+T_W+2:0] mix_s;
  logic                      out_free, all_zero, normed;
  logic [COMP_W-1:0]         cand;
  logic [63:0]               cand_sq;
  logic [QW-1:0]             quo_n;
  logic [REM_W-1:0]          rem_n;

  assign out_free = !out_valid_r || out_ready;
  assign all_zero = (mag_r[0] | mag_r[1] | mag_r[2]) == '0;
  assign normed   = (mag_r[0][COMP_W-1:COMP_W-2] | mag_r[1][COMP_W-1:COMP_W-2]
                     | mag_r[2][COMP_W-1:COMP_W-2]) != '0;

  // blend of one component
  always_comb begin
    mix_a = start_rd_r[c_r*COMP_W +: COMP_W];
    mix_b = end_rd_r[c_r*COMP_W +: COMP_W];
    mix_d = {mix_b[COMP_W-1], mix_b} - {mix_a[COMP_W-1], mix_a};
    mix_p = mix_d * $signed({1'b0, t_r});
    mix_s = ((COMP_W+T_W+3)'(mix_a) <<< T_FRAC) + (COMP_W+T_W+3)'(mix_p)
            + (COMP_W+T_W+3)'(T_ONE >> 1);
    mix_v = mix_s[T_FRAC +: COMP_W];
  end

  assign cand    = root_r | (COMP_W'(1) << bit_r);
  assign cand_sq = 64'(cand) * 64'(cand);

  always_comb begin
    if (rem_r >= den_r) begin
      rem_n = rem_r - den_r;
      quo_n = {quo_r[QW-2:0], 1'b1};
    end else begin
      rem_n = rem_r;
      quo_n = {quo_r[QW-2:0], 1'b0};
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (q_not_empty && q_head.op == OP_QUERY) state_nxt = ST_RD;
      ST_RD:    state_nxt = (k_r == KIND_TEX) ? ST_EMIT : ST_MIX;
      ST_MIX:   if (c_r == 2'd2) state_nxt = (k_r == KIND_POS) ? ST_EMIT : ST_SHIFT;
      ST_SHIFT: begin
        if (all_zero)    state_nxt = ST_EMIT;
        else if (normed) state_nxt = ST_SQ;
      end
      ST_SQ:    if (c_r == 2'd2) state_nxt = ST_SQRT;
      ST_SQRT:  if (bit_r == '0) state_nxt = ST_DINIT;
      ST_DINIT: state_nxt = ST_DIV;
      ST_DIV:   if (it_r == '0) state_nxt = (c_r == 2'd2) ? ST_EMIT : ST_DINIT;
      ST_EMIT:  if (out_free) state_nxt = (k_r == KIND_TEX) ? ST_IDLE : ST_RD;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctl = '0;
    case (state_r)
      ST_IDLE: begin
        ctl.pop      = q_not_empty;
        ctl.wr_start = q_not_empty && q_head.op == OP_LOAD_START;
        ctl.wr_end   = q_not_empty && q_head.op == OP_LOAD_END;
      end
      ST_EMIT: ctl.out_load = out_free;
      default: ctl = '0;
    endcase
  end

  assign q_pop = ctl.pop;

  always_ff @(posedge clk) begin
    if (ctl.wr_start) begin
      start_mem[{q_head.idx, q_head.kind}] <= {q_head.z, q_head.y, q_head.x};
    end
    if (ctl.wr_end) begin
      end_mem[{q_head.idx, q_head.kind[1:0]}] <= {q_head.z, q_head.y, q_head.x};
    end
    start_rd_r <= start_mem[{idx_r, k_r}];
    end_rd_r   <= end_mem[{idx_r, k_r[1:0]}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        idx_r <= q_head.idx;
        t_r   <= q_head.t;
        k_r   <= KIND_POS;
        c_r   <= '0;
      end
      ST_RD: c_r <= '0;
      ST_MIX: begin
        vec_r[c_r] <= mix_v;
        mag_r[c_r] <= mix_v[COMP_W-1] ? COMP_W'(-mix_v) : COMP_W'(mix_v);
        neg_r[c_r] <= mix_v[COMP_W-1];
        c_r        <= (c_r == 2'd2) ? 2'd0 : c_r + 2'd1;
        len_r      <= '0;
      end
      ST_SHIFT: begin
        if (all_zero) begin
          vec_r[0] <= '0;
          vec_r[1] <= '0;
          vec_r[2] <= '0;
        end else if (!normed) begin
          mag_r[0] <= mag_r[0] << 1;
          mag_r[1] <= mag_r[1] << 1;
          mag_r[2] <= mag_r[2] << 1;
        end
      end
      ST_SQ: begin
        len_r  <= len_r + 64'(mag_r[c_r]) * 64'(mag_r[c_r]);
        c_r    <= (c_r == 2'd2) ? 2'd0 : c_r + 2'd1;
        root_r <= '0;
        bit_r  <= 5'(COMP_W - 1);
      end
      ST_SQRT: begin
        if (cand_sq <= len_r) root_r <= cand;
        bit_r <= bit_r - 5'd1;
      end
      ST_DINIT: begin
        rem_r <= (REM_W'(mag_r[c_r]) << FRAC_BITS) + REM_W'(root_r >> 1);
        den_r <= REM_W'(root_r) << (QW - 1);
        quo_r <= '0;
        it_r  <= 5'(QW - 1);
      end
      ST_DIV: begin
        rem_r <= rem_n;
        den_r <= den_r >> 1;
        quo_r <= quo_n;
        it_r  <= it_r - 5'd1;
        if (it_r == '0) begin
          vec_r[c_r] <= neg_r[c_r] ? -COMP_W'(quo_n) : COMP_W'(quo_n);
          c_r        <= (c_r == 2'd2) ? 2'd0 : c_r + 2'd1;
        end
      end
      ST_EMIT: if (out_free) k_r <= k_r + 3'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_kind_r <= k_r;
      out_last_r <= k_r == KIND_TEX;
      if (k_r == KIND_TEX) begin
        out_x_r <= start_rd_r[0 +: COMP_W];
        out_y_r <= start_rd_r[COMP_W +: COMP_W];
        out_z_r <= '0;
      end else begin
        out_x_r <= vec_r[0];
        out_y_r <= vec_r[1];
        out_z_r <= vec_r[2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_x              = out_x_r;
  assign out_y              = out_y_r;
  assign out_z              = out_z_r;
  assign out_last_of_vertex = out_last_r;

`ifndef SYNTHESIS
  a_norm_before_sq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQ) |-> normed) else $error("square before normalising shift");
  a_last_on_tex: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |=> out_last_r == ($past(k_r) == KIND_TEX)) else $error("last flag slip");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !ctl.out_load) else $error("result overwritten");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == ST_IDLE) else $error("pop while busy");
`endif

endmodule
`default_nettype wire

### rtl/core/vertex_morph_interpolator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_morph_interpolator_top
// morphs a vertex between a start and an end table, normalising the frame
//
// input channel: in_valid/in_ready carry loads of one start or end vector
// and queries of one vertex at a blend time. result channel: out_valid/
// out_ready carry position, normal, tangent u, tangent v and texcoord of a
// query, the texcoord flagged by out_last_of_vertex.
// the front takes a transaction whenever the four-entry queue has room, so
// input is taken while the back still works or a result waits.
// a load is written straight from the idle state. a query pops, reads,
// blends three components and emits the position; each normalised vector
// is read, blended, shifted until normalised, squared, rooted bit by bit,
// divided per component and emitted, or emitted as zero when of zero
// length; the texcoord is read and emitted last.
// reset clears queue, sequencer and result valid; table contents stay
// undefined until written. when out_ready is low the result register holds
// and the back waits; the queue keeps taking input until it is full.
// ----------------------------------------------------------------------------
module vertex_morph_interpolator_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         in_action,
  input  wire logic [vmi_pkg::IDX_W-1:0]          in_vertex_index,
  input  wire logic [2:0]                         in_vector_kind,
  input  wire logic signed [vmi_pkg::COMP_W-1:0]  in_comp_x,
  input  wire logic signed [vmi_pkg::COMP_W-1:0]  in_comp_y,
  input  wire logic signed [vmi_pkg::COMP_W-1:0]  in_comp_z,
  input  wire logic [vmi_pkg::T_W-1:0]            in_blend_time,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [2:0]                              out_kind,
  output logic signed [vmi_pkg::COMP_W-1:0]       out_x,
  output logic signed [vmi_pkg::COMP_W-1:0]       out_y,
  output logic signed [vmi_pkg::COMP_W-1:0]       out_z,
  output logic                                    out_last_of_vertex
);
  import vmi_pkg::*;

  logic q_full, q_push, q_pop, q_not_empty;
  cmd_t q_cmd, q_head;

  vmi_front u_front (
    .in_valid, .in_ready, .in_action, .in_vertex_index, .in_vector_kind,
    .in_comp_x, .in_comp_y, .in_comp_z, .in_blend_time,
    .q_full, .q_push, .q_cmd
  );

  vmi_fifo u_fifo (
    .clk, .rst_n, .push(q_push), .push_cmd(q_cmd), .full(q_full),
    .pop(q_pop), .not_empty(q_not_empty), .head(q_head)
  );

  vmi_back u_back (
    .clk, .rst_n, .q_not_empty, .q_head, .q_pop,
    .out_valid, .out_ready, .out_kind, .out_x, .out_y, .out_z,
    .out_last_of_vertex
  );

endmodule
`default_nettype wire

### dv/vmi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmi_checker
// watches both channels of the vertex morph interpolator, keeps its own copy
// of the start and end vertex tables, works out the five vectors of every
// query and compares each result transaction field by field in order
// ----------------------------------------------------------------------------
module vmi_checker (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  input  wire logic                              in_ready,
  input  wire logic [1:0]                        in_action,
  input  wire logic [vmi_pkg::IDX_W-1:0]         in_vertex_index,
  input  wire logic [2:0]                        in_vector_kind,
  input  wire logic signed [vmi_pkg::COMP_W-1:0] in_comp_x,
  input  wire logic signed [vmi_pkg::COMP_W-1:0] in_comp_y,
  input  wire logic signed [vmi_pkg::COMP_W-1:0] in_comp_z,
  input  wire logic [vmi_pkg::T_W-1:0]           in_blend_time,
  input  wire logic                              out_valid,
  input  wire logic                              out_ready,
  input  wire logic [2:0]                        out_kind,
  input  wire logic signed [vmi_pkg::COMP_W-1:0] out_x,
  input  wire logic signed [vmi_pkg::COMP_W-1:0] out_y,
  input  wire logic signed [vmi_pkg::COMP_W-1:0] out_z,
  input  wire logic                              out_last_of_vertex,
  output int                                     error_count,
  output int                                     vectors_pending
);
  import vmi_pkg::*;

  typedef struct {
    logic [2:0]               kind;
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
    logic                     last;
  } vec_result_t;

  logic signed [COMP_W-1:0] start_tab [VERTEX_COUNT][14];
  logic signed [COMP_W-1:0] end_tab [VERTEX_COUNT][12];
  vec_result_t              expected_vectors [$];

  function automatic longint blend_comp(longint a, longint b, longint t);
    longint sum;
    sum = a * (65536 - t) + b * t + 32768;
    return sum >>> 16;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic void unit_vector(input longint v [3], output longint n [3]);
    longint unsigned mag [3];
    longint unsigned m, len_sq, r, q;
    m = 0;
    len_sq = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? -v[i] : v[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      n = '{0, 0, 0};
      return;
    end
    while (m < (64'd1 << 30)) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    for (int i = 0; i < 3; i++) len_sq += mag[i] * mag[i];
    r = root_floor(len_sq);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FRAC_BITS) + r / 2) / r;
      n[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  task automatic predict_query(int idx, longint t);
    longint      v [3];
    longint      n [3];
    vec_result_t res;
    if (t > 65536) t = 65536;
    for (int k = 0; k < 4; k++) begin
      for (int c = 0; c < 3; c++)
        v[c] = blend_comp(start_tab[idx][k*3+c], end_tab[idx][k*3+c], t);
      if (k != 0) unit_vector(v, n);
      else n = v;
      res.kind = 3'(k);
      res.x = n[0][31:0];
      res.y = n[1][31:0];
      res.z = n[2][31:0];
      res.last = 1'b0;
      expected_vectors.insert(expected_vectors.size(), res);
    end
    res.kind = KIND_TEX;
    res.x = start_tab[idx][12];
    res.y = start_tab[idx][13];
    res.z = '0;
    res.last = 1'b1;
    expected_vectors.insert(expected_vectors.size(), res);
  endtask

  always @(posedge clk) begin
    vec_result_t exp_v;
    int          idx;
    if (!rst_n) begin
      error_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_vectors.size() == 0) begin
          if (error_count < 10)
            $display("%0t: unexpected result kind %0d x %h y %h z %h last %b", $time,
                     out_kind, out_x, out_y, out_z, out_last_of_vertex);
          error_count <= error_count + 1;
        end else begin
          exp_v = expected_vectors.pop_front();
          if (exp_v.kind !== out_kind || exp_v.x !== out_x || exp_v.y !== out_y ||
              exp_v.z !== out_z || exp_v.last !== out_last_of_vertex) begin
            if (error_count < 10)
              $display({"%0t: mismatch exp kind %0d x %h y %h z %h last %b, ",
                        "got kind %0d x %h y %h z %h last %b"},
                       $time, exp_v.kind, exp_v.x, exp_v.y, exp_v.z, exp_v.last,
                       out_kind, out_x, out_y, out_z, out_last_of_vertex);
            error_count <= error_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        idx = int'(in_vertex_index);
        case (action_t'(in_action))
          ACT_LOAD_START: begin
            if (in_vector_kind < KIND_TEX) begin
              start_tab[idx][in_vector_kind*3]   = in_comp_x;
              start_tab[idx][in_vector_kind*3+1] = in_comp_y;
              start_tab[idx][in_vector_kind*3+2] = in_comp_z;
            end else if (in_vector_kind == KIND_TEX) begin
              start_tab[idx][12] = in_comp_x;
              start_tab[idx][13] = in_comp_y;
            end
          end
          ACT_LOAD_END: begin
            if (in_vector_kind < KIND_TEX) begin
              end_tab[idx][in_vector_kind*3]   = in_comp_x;
              end_tab[idx][in_vector_kind*3+1] = in_comp_y;
              end_tab[idx][in_vector_kind*3+2] = in_comp_z;
            end
          end
          ACT_QUERY: predict_query(idx, longint'(in_blend_time));
          default: ;
        endcase
      end
    end
    vectors_pending = expected_vectors.size();
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives loads and queries into the vertex morph interpolator under several
// idling and stalling mixes; the checker predicts and compares the results
// ----------------------------------------------------------------------------
module testbench;
  import vmi_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int POOL_SIZE      = 6;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               in_action;
  logic [IDX_W-1:0]         in_vertex_index;
  logic [2:0]               in_vector_kind;
  logic signed [COMP_W-1:0] in_comp_x;
  logic signed [COMP_W-1:0] in_comp_y;
  logic signed [COMP_W-1:0] in_comp_z;
  logic [T_W-1:0]           in_blend_time;
  logic                     out_valid;
  logic                     out_ready;
  logic [2:0]               out_kind;
  logic signed [COMP_W-1:0] out_x;
  logic signed [COMP_W-1:0] out_y;
  logic signed [COMP_W-1:0] out_z;
  logic                     out_last_of_vertex;
  int                       error_count;
  int                       vectors_pending;
  int                       send_idle_pct;
  int                       recv_stall_pct;
  int                       quiet_cycles;
  bit                       start_written [VERTEX_COUNT][5];
  bit                       end_written [VERTEX_COUNT][4];
  int                       vertex_pool [POOL_SIZE];

  vertex_morph_interpolator_top i_dut (.*);

  vmi_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic bit vertex_complete(int idx);
    for (int k = 0; k < 5; k++) if (!start_written[idx][k]) return 0;
    for (int k = 0; k < 4; k++) if (!end_written[idx][k]) return 0;
    return 1;
  endfunction

  task automatic send_transaction(action_t act, int idx, int kind, logic [31:0] x,
                                  logic [31:0] y, logic [31:0] z, int t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_vertex_index <= IDX_W'(idx);
    in_vector_kind  <= 3'(kind);
    in_comp_x       <= x;
    in_comp_y       <= y;
    in_comp_z       <= z;
    in_blend_time   <= T_W'(t);
    do @(posedge clk); while (!in_ready);
    if (act == ACT_LOAD_START && kind <= KIND_TEX) start_written[idx][kind] = 1;
    if (act == ACT_LOAD_END && kind < KIND_TEX) end_written[idx][kind] = 1;
  endtask

  task automatic load_full_vertex(int idx);
    for (int k = KIND_POS; k <= KIND_TEX; k++)
      send_transaction(ACT_LOAD_START, idx, k, $urandom, $urandom, $urandom, $urandom);
    for (int k = KIND_POS; k <= KIND_TANV; k++)
      send_transaction(ACT_LOAD_END, idx, k, $urandom, $urandom, $urandom, $urandom);
  endtask

  function automatic int pick_blend();
    case ($urandom_range(4))
      0: return 0;
      1: return int'(T_ONE);
      2: return $urandom_range(65537, 131071);
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  task automatic random_transaction();
    int          idx, r, kind;
    logic [31:0] x, y, z;
    idx = vertex_pool[$urandom_range(POOL_SIZE-1)];
    r = $urandom_range(99);
    x = $urandom;
    y = $urandom;
    z = $urandom;
    if ($urandom_range(9) == 0) begin
      x = 0;
      y = 0;
      z = 0;
    end
    if (r < 35) begin
      send_transaction(ACT_LOAD_START, idx, $urandom_range(KIND_POS, KIND_TEX), x, y, z,
                       $urandom);
    end else if (r < 55) begin
      send_transaction(ACT_LOAD_END, idx, $urandom_range(KIND_POS, KIND_TANV), x, y, z,
                       $urandom);
    end else if (r < 88) begin
      if (vertex_complete(idx)) send_transaction(ACT_QUERY, idx, $urandom_range(7), x, y, z,
                                                 pick_blend());
      else load_full_vertex(idx);
    end else begin
      case ($urandom_range(3))
        0: send_transaction(ACT_NONE, $urandom_range(1023), $urandom_range(7), x, y, z,
                            $urandom);
        1: send_transaction(ACT_LOAD_START, $urandom_range(1023), $urandom_range(5, 7),
                            x, y, z, $urandom);
        2: send_transaction(ACT_LOAD_END, idx, KIND_TEX, x, y, z, $urandom);
        default: begin
          kind = $urandom_range(KIND_POS, KIND_TEX);
          send_transaction(ACT_LOAD_START, $urandom_range(1023), kind, x, y, z, $urandom);
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (vectors_pending != 0);
  endtask

  initial begin
    int pct_send [4];
    int pct_recv [4];
    pct_send = '{0, 46, 0, 18};
    pct_recv = '{0, 0, 46, 18};
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_action       = ACT_NONE;
    in_vertex_index = '0;
    in_vector_kind  = '0;
    in_comp_x       = '0;
    in_comp_y       = '0;
    in_comp_z       = '0;
    in_blend_time   = '0;
    out_ready       = 1'b0;
    quiet_cycles    = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    vertex_pool[0] = 0;
    vertex_pool[1] = VERTEX_COUNT - 1;
    for (int i = 2; i < POOL_SIZE; i++) vertex_pool[i] = $urandom_range(1, VERTEX_COUNT - 2);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, zero-length frame and blend edges
    for (int k = KIND_POS; k <= KIND_TEX; k++)
      send_transaction(ACT_LOAD_START, 0, k, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 0);
    send_transaction(ACT_LOAD_END, 0, KIND_POS, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 0);
    send_transaction(ACT_LOAD_END, 0, KIND_NRM, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 0);
    send_transaction(ACT_LOAD_END, 0, KIND_TANU, 32'h0, 32'h0, 32'h0, 0);
    send_transaction(ACT_LOAD_END, 0, KIND_TANV, 32'h1, 32'h0, 32'h0, 0);
    send_transaction(ACT_QUERY, 0, KIND_POS, 0, 0, 0, 0);
    send_transaction(ACT_QUERY, 0, KIND_POS, 0, 0, 0, 32768);
    send_transaction(ACT_QUERY, 0, KIND_POS, 0, 0, 0, int'(T_ONE));
    send_transaction(ACT_QUERY, 0, KIND_POS, 0, 0, 0, 131071);
    send_transaction(ACT_LOAD_END, 0, KIND_TEX, 32'h1234, 32'h5678, 32'h9abc, 0);
    send_transaction(ACT_LOAD_START, 0, 7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0);
    send_transaction(ACT_NONE, 1023, 5, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 131071);
    send_transaction(ACT_QUERY, 0, KIND_POS, 0, 0, 0, 1);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = pct_send[ph];
      recv_stall_pct = pct_recv[ph];
      for (int i = 0; i < 36; i++) random_transaction();
      if (ph == 1) wait_drained();
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (vectors_pending != 0);
    repeat (50) @(posedge clk);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
